>>> src/rtp_pkg.sv
package rtp_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_GOT3,
    PH_GOT1,
    PH_DUR,
    PH_NOTE,
    PH_DOT1,
    PH_OCT,
    PH_END
  } phase_e;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_P     = 8'h70;

  // letter slot used for the rest letter
  localparam logic [2:0] LETTER_REST = 3'd7;

  localparam logic [7:0] CFG_DEFAULT_OCTAVE   = 8'd0;
  localparam logic [7:0] CFG_DEFAULT_DURATION = 8'd1;

  localparam logic [2:0] OCTAVE_RESET   = 3'd5;
  localparam logic [2:0] DURATION_RESET = 3'd2;

  localparam logic [2:0] DUR_WHOLE   = 3'd0;
  localparam logic [2:0] DUR_HALF    = 3'd1;
  localparam logic [2:0] DUR_QUARTER = 3'd2;
  localparam logic [2:0] DUR_EIGHTH  = 3'd3;
  localparam logic [2:0] DUR_16TH    = 3'd4;
  localparam logic [2:0] DUR_32ND    = 3'd5;

  localparam logic [7:0] TICKS_WHOLE = 8'hff;
  localparam logic [2:0] OCTAVE_BASE = 3'd4;

  typedef struct packed {
    logic [2:0] octave;
    logic [2:0] duration;
  } rtp_cfg_t;

  typedef struct packed {
    logic [15:0] period_reload;
    logic [8:0]  tick_count;
    logic        is_rest;
    logic        last;
  } rtp_note_t;

  function automatic logic [15:0] natural_period(input logic [2:0] idx);
    logic [15:0] p;
    case (idx)
      3'd0:    p = 16'd11364;
      3'd1:    p = 16'd10123;
      3'd2:    p = 16'd9555;
      3'd3:    p = 16'd8513;
      3'd4:    p = 16'd7584;
      3'd5:    p = 16'd7158;
      3'd6:    p = 16'd6378;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

  // zero where the letter has no sharp
  function automatic logic [15:0] sharp_period(input logic [2:0] idx);
    logic [15:0] p;
    case (idx)
      3'd0:    p = 16'd10726;
      3'd2:    p = 16'd9019;
      3'd3:    p = 16'd8035;
      3'd5:    p = 16'd6757;
      3'd6:    p = 16'd6024;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

endpackage

>>> src/rtp_if.sv
interface rtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface rtp_note_if;
  logic        valid;
  logic        ready;
  logic [15:0] period_reload;
  logic [8:0]  tick_count;
  logic        is_rest;
  logic        last;

  modport source (output valid, output period_reload, output tick_count,
                  output is_rest, output last, input ready);
  modport sink (input valid, input period_reload, input tick_count,
                input is_rest, input last, output ready);
endinterface

interface rtp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/rtp_core.sv
module rtp_core import rtp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  logic [7:0] ch_i,
  input  rtp_cfg_t  cfg_i,
  output logic      emit_o,
  output rtp_note_t note_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  dur_q, dur_d;
  logic        dotted_q, dotted_d;
  logic [2:0]  oct_q, oct_d;
  logic [2:0]  letter_q, letter_d;
  logic        sharp_ok_q, sharp_ok_d;
  logic [15:0] period_q, period_d;

  logic        is_letter, is_digit, is_sharp, ends_melody;
  logic [2:0]  letter_idx;
  logic [1:0]  shift;
  logic [7:0]  ticks;
  logic [15:0] sharp_p;

  assign is_letter   = (ch_i >= CH_A && ch_i <= CH_G) || ch_i == CH_P;
  assign is_digit    = ch_i >= CH_4 && ch_i <= CH_7;
  assign is_sharp    = ch_i == CH_HASH || ch_i == CH_UNDER;
  assign ends_melody = ch_i != CH_COMMA;
  assign letter_idx  = (ch_i == CH_P) ? LETTER_REST : 3'(ch_i - CH_A);
  assign sharp_p     = sharp_period(letter_q);

  assign shift = (oct_q > OCTAVE_BASE) ? 2'(oct_q - OCTAVE_BASE) : 2'd0;
  assign ticks = TICKS_WHOLE >> dur_q;

  always_comb begin
    phase_d    = phase_q;
    dur_d      = dur_q;
    dotted_d   = dotted_q;
    oct_d      = oct_q;
    letter_d   = letter_q;
    sharp_ok_d = sharp_ok_q;
    period_d   = period_q;
    emit_o     = 1'b0;

    note_o.last          = ends_melody;
    note_o.is_rest       = (period_q == 16'd0);
    note_o.period_reload = (period_q == 16'd0) ? 16'd0 : ~(period_q >> shift);
    note_o.tick_count    = dotted_q ? ({1'b0, ticks} + {2'b00, ticks[7:1]})
                                    : {1'b0, ticks};

    case (phase_q)
      PH_START: begin
        if (ch_i == CH_3) begin
          phase_d = PH_GOT3;
        end else if (ch_i == CH_1) begin
          phase_d = PH_GOT1;
        end else if (ch_i == CH_8) begin
          dur_d   = DUR_EIGHTH;
          phase_d = PH_DUR;
        end else if (ch_i == CH_4) begin
          dur_d   = DUR_QUARTER;
          phase_d = PH_DUR;
        end else if (ch_i == CH_2) begin
          dur_d   = DUR_HALF;
          phase_d = PH_DUR;
        end else if (is_letter) begin
          dur_d   = cfg_i.duration;
          phase_d = PH_NOTE;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_GOT3: begin
        if (ch_i == CH_2) begin
          dur_d   = DUR_32ND;
          phase_d = PH_DUR;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_GOT1: begin
        if (ch_i == CH_6) begin
          dur_d   = DUR_16TH;
          phase_d = PH_DUR;
        end else if (is_letter) begin
          dur_d   = DUR_WHOLE;
          phase_d = PH_NOTE;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_DUR: begin
        if (is_letter) begin
          phase_d = PH_NOTE;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_NOTE: begin
        if (is_sharp && sharp_ok_q) begin
          // sharp on b, e or the rest letter is taken but leaves the period unchanged
          if (sharp_p != 16'd0) begin
            period_d = sharp_p;
          end
          sharp_ok_d = 1'b0;
        end else if (ch_i == CH_DOT) begin
          dotted_d = ~dotted_q;
          phase_d  = PH_DOT1;
        end else if (is_digit) begin
          oct_d   = 3'(ch_i - CH_0);
          phase_d = PH_OCT;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_DOT1: begin
        if (ch_i == CH_DOT) begin
          dotted_d = ~dotted_q;
          phase_d  = PH_END;
        end else if (is_digit) begin
          oct_d   = 3'(ch_i - CH_0);
          phase_d = PH_OCT;
        end else begin
          emit_o = 1'b1;
        end
      end
      PH_OCT: begin
        if (ch_i == CH_DOT) begin
          dotted_d = ~dotted_q;
          phase_d  = PH_END;
        end else begin
          emit_o = 1'b1;
        end
      end
      default: begin
        emit_o = 1'b1;
      end
    endcase

    // letter arrival loads the note fields
    if (phase_d == PH_NOTE && phase_q != PH_NOTE) begin
      letter_d   = letter_idx;
      sharp_ok_d = 1'b1;
      period_d   = (letter_idx == LETTER_REST) ? 16'd0 : natural_period(letter_idx);
      oct_d      = cfg_i.octave;
      dotted_d   = 1'b0;
    end

    // empty rest fields, then clear for the next note
    if (emit_o && (phase_q == PH_START || phase_q == PH_GOT3 ||
                   phase_q == PH_GOT1 || phase_q == PH_DUR)) begin
      note_o.period_reload = 16'd0;
      note_o.tick_count    = 9'd0;
      note_o.is_rest       = 1'b1;
    end
    if (emit_o) begin
      phase_d    = PH_START;
      dur_d      = 3'd0;
      dotted_d   = 1'b0;
      oct_d      = 3'd0;
      letter_d   = 3'd0;
      sharp_ok_d = 1'b0;
      period_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      dur_q      <= 3'd0;
      dotted_q   <= 1'b0;
      oct_q      <= 3'd0;
      letter_q   <= 3'd0;
      sharp_ok_q <= 1'b0;
      period_q   <= 16'd0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      dur_q      <= dur_d;
      dotted_q   <= dotted_d;
      oct_q      <= oct_d;
      letter_q   <= letter_d;
      sharp_ok_q <= sharp_ok_d;
      period_q   <= period_d;
    end
  end

endmodule

>>> src/rtttl_note_parser_top.sv
// a note word is registered and appears on note_o in the cycle after the ending character is taken
// one character per cycle while a waiting note word is not stalled by the sink
// the output register frees in the same cycle it is read, so a stalled sink alone
// holds back char_i
// reset: parser waits for the start of a note, octave 5 and quarter notes by default
module rtttl_note_parser_top import rtp_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  rtp_char_if.sink     char_i,
  rtp_cfg_if.sink      cfg_i,
  rtp_note_if.source   note_o
);

  rtp_cfg_t  cfg_q;
  rtp_note_t res, out_q;
  logic      out_valid_q;
  logic      take, emit;

  assign cfg_i.ready  = 1'b1;
  assign char_i.ready = !out_valid_q || note_o.ready;
  assign take         = char_i.valid && char_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave   <= OCTAVE_RESET;
      cfg_q.duration <= DURATION_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_DEFAULT_OCTAVE) begin
        cfg_q.octave <= cfg_i.data[2:0];
      end else if (cfg_i.index == CFG_DEFAULT_DURATION) begin
        cfg_q.duration <= cfg_i.data[2:0];
      end
    end
  end

  rtp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (char_i.ch),
    .cfg_i  (cfg_q),
    .emit_o (emit),
    .note_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= emit;
    end else if (note_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= res;
    end
  end

  assign note_o.valid         = out_valid_q;
  assign note_o.period_reload = out_q.period_reload;
  assign note_o.tick_count    = out_q.tick_count;
  assign note_o.is_rest       = out_q.is_rest;
  assign note_o.last          = out_q.last;

  // a waiting word must block new characters
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_o.valid && !note_o.ready |-> !char_i.ready)
    else $error("character taken while note word stalled");

  // a rest never carries a tone period
  a_rest_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_o.valid && note_o.is_rest |-> note_o.period_reload == 16'd0)
    else $error("rest with nonzero period");

  // a taken character that ends a note shows up as a word next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && emit |=> note_o.valid)
    else $error("note word lost");

endmodule
